[hw/rtl/ille_pkg.sv]
// Shared constants and codes of the indexed linked list engine.
package ille_pkg;

    localparam int NODE_SLOTS = 256;
    localparam int IDX_W      = $clog2(NODE_SLOTS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int LIST_COUNT = 4;
    localparam int SEL_W      = $clog2(LIST_COUNT);
    localparam int OP_W       = 4;

    typedef logic [LINK_W-1:0] t_link;

    localparam t_link NONE = '1;

    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd0;
    localparam logic [OP_W-1:0] OP_APPEND     = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_HEAD   = 4'd2;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 4'd3;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 4'd4;
    localparam logic [OP_W-1:0] OP_DELETE     = 4'd5;
    localparam logic [OP_W-1:0] OP_POP_HEAD   = 4'd6;
    localparam logic [OP_W-1:0] OP_POP_TAIL   = 4'd7;
    localparam logic [OP_W-1:0] OP_NEXT       = 4'd8;
    localparam logic [OP_W-1:0] OP_PREV       = 4'd9;
    localparam logic [OP_W-1:0] OP_CHECK      = 4'd10;
    localparam logic [OP_W-1:0] OP_FILL       = 4'd11;

endpackage

[hw/rtl/ille_ram.sv]
// Generic single write, single read RAM with registered read data.
module ille_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/indexed_linked_list_engine_unit.sv]
// Top level of the indexed linked list engine: sequencer, list stores, link RAMs.
// Steps from accept: clear/failed ops decode, finish; append/insert-head decode, link2,
// finish; delete/pop/next/prev decode, link, finish; insert before/after decode, link,
// link2, finish; fill a step per node; check a walk and walk-wait step per node each way,
// a walk step per end-of-walk test. One item at a time: the next item is accepted the
// cycle after the result is registered; a stalled result holds the sequencer in finish.
// Reset (synchronous, active low) empties all lists and sets nodes_in_use to 256;
// link RAM contents are not cleared and are undefined until written.
module indexed_linked_list_engine_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input item channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [3:0]              i_operation,
    input  logic [1:0]              i_list_select,
    input  logic signed [8:0]       i_node_index,
    input  logic signed [8:0]       i_anchor_index,
    // result item channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_status,
    output logic signed [8:0]       o_result_index,
    output logic signed [8:0]       o_list_head,
    output logic signed [8:0]       o_list_tail,
    output logic [8:0]              o_list_count,
    // nodes_in_use write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [8:0]              i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_LINK   = 3'd2;
    localparam logic [2:0] S_LINK2  = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_WWAIT  = 3'd5;
    localparam logic [2:0] S_FILL   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    localparam int IW = ille_pkg::IDX_W;
    localparam int LW = ille_pkg::LINK_W;

    logic [2:0]                      r_state;
    logic [ille_pkg::OP_W-1:0]       r_op;
    logic [ille_pkg::SEL_W-1:0]      r_sel;
    ille_pkg::t_link                 r_node;
    ille_pkg::t_link                 r_anc;
    ille_pkg::t_link                 r_tmp;
    ille_pkg::t_link                 r_at;
    logic [LW-1:0]                   r_seen;
    logic                            r_dir;
    logic [IW-1:0]                   r_idx;
    logic [LW-1:0]                   r_niu;
    logic                            r_status;
    ille_pkg::t_link                 r_res;

    ille_pkg::t_link                 r_head  [ille_pkg::LIST_COUNT];
    ille_pkg::t_link                 r_tail  [ille_pkg::LIST_COUNT];
    logic [LW-1:0]                   r_count [ille_pkg::LIST_COUNT];

    logic                            r_out_valid;
    logic                            r_out_status;
    ille_pkg::t_link                 r_out_res;
    ille_pkg::t_link                 r_out_head;
    ille_pkg::t_link                 r_out_tail;
    logic [LW-1:0]                   r_out_count;

    // link RAM ports
    logic                            wn_en, wp_en;
    logic [IW-1:0]                   wn_addr, wp_addr, rd_addr;
    ille_pkg::t_link                 wn_data, wp_data, nxt_q, prv_q;

    ille_pkg::t_link                 cur_head, cur_tail, pos;
    logic [LW-1:0]                   cur_cnt;
    logic                            empty, full, node_ok, anc_ok, fill_last;

    assign cur_head  = r_head[r_sel];
    assign cur_tail  = r_tail[r_sel];
    assign cur_cnt   = r_count[r_sel];
    assign empty     = (cur_cnt == '0);
    assign full      = (cur_cnt == LW'(ille_pkg::NODE_SLOTS));
    assign node_ok   = ~r_node[LW-1];
    assign anc_ok    = ~r_anc[LW-1];
    assign pos       = (r_op == ille_pkg::OP_POP_HEAD) ? cur_head : cur_tail;
    assign fill_last = (({1'b0, r_idx} + LW'(1)) == r_niu);

    ille_ram #(.WIDTH(LW), .DEPTH(ille_pkg::NODE_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (wn_en),
        .i_waddr (wn_addr),
        .i_wdata (wn_data),
        .i_raddr (rd_addr),
        .o_rdata (nxt_q)
    );

    ille_ram #(.WIDTH(LW), .DEPTH(ille_pkg::NODE_SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (wp_en),
        .i_waddr (wp_addr),
        .i_wdata (wp_data),
        .i_raddr (rd_addr),
        .o_rdata (prv_q)
    );

    // link RAM write and read steering per sequencer step
    always_comb begin
        wn_en   = 1'b0;
        wn_addr = r_node[IW-1:0];
        wn_data = ille_pkg::NONE;
        wp_en   = 1'b0;
        wp_addr = r_node[IW-1:0];
        wp_data = ille_pkg::NONE;
        rd_addr = r_at[IW-1:0];
        case (r_state)
            S_DECODE: begin
                case (r_op)
                    ille_pkg::OP_APPEND: begin
                        if (node_ok && !full) begin
                            wp_en   = 1'b1;
                            wp_data = empty ? ille_pkg::NONE : cur_tail;
                            if (!empty && !cur_tail[LW-1]) begin
                                wn_en   = 1'b1;
                                wn_addr = cur_tail[IW-1:0];
                                wn_data = r_node;
                            end
                        end
                    end
                    ille_pkg::OP_INS_HEAD: begin
                        if (node_ok && !full) begin
                            wn_en   = 1'b1;
                            wn_data = empty ? ille_pkg::NONE : cur_head;
                            if (!empty && !cur_head[LW-1]) begin
                                wp_en   = 1'b1;
                                wp_addr = cur_head[IW-1:0];
                                wp_data = r_node;
                            end
                        end
                    end
                    ille_pkg::OP_INS_BEFORE, ille_pkg::OP_INS_AFTER: rd_addr = r_anc[IW-1:0];
                    ille_pkg::OP_POP_HEAD, ille_pkg::OP_POP_TAIL:    rd_addr = pos[IW-1:0];
                    default:                                         rd_addr = r_node[IW-1:0];
                endcase
            end
            S_LINK: begin
                case (r_op)
                    ille_pkg::OP_INS_BEFORE: begin
                        wn_en   = 1'b1;
                        wn_data = r_anc;
                        wp_en   = 1'b1;
                        wp_data = prv_q;
                    end
                    ille_pkg::OP_INS_AFTER: begin
                        wn_en   = 1'b1;
                        wn_data = nxt_q;
                        wp_en   = 1'b1;
                        wp_data = r_anc;
                    end
                    ille_pkg::OP_DELETE, ille_pkg::OP_POP_HEAD, ille_pkg::OP_POP_TAIL: begin
                        // unlink: bridge predecessor and successor
                        if (!prv_q[LW-1]) begin
                            wn_en   = 1'b1;
                            wn_addr = prv_q[IW-1:0];
                            wn_data = nxt_q;
                        end
                        if (!nxt_q[LW-1]) begin
                            wp_en   = 1'b1;
                            wp_addr = nxt_q[IW-1:0];
                            wp_data = prv_q;
                        end
                    end
                    default: ;
                endcase
            end
            S_LINK2: begin
                case (r_op)
                    ille_pkg::OP_APPEND:   wn_en = 1'b1;
                    ille_pkg::OP_INS_HEAD: wp_en = 1'b1;
                    ille_pkg::OP_INS_BEFORE: begin
                        wn_en   = !r_tmp[LW-1];
                        wn_addr = r_tmp[IW-1:0];
                        wn_data = r_node;
                        wp_en   = 1'b1;
                        wp_addr = r_anc[IW-1:0];
                        wp_data = r_node;
                    end
                    ille_pkg::OP_INS_AFTER: begin
                        wp_en   = !r_tmp[LW-1];
                        wp_addr = r_tmp[IW-1:0];
                        wp_data = r_node;
                        wn_en   = 1'b1;
                        wn_addr = r_anc[IW-1:0];
                        wn_data = r_node;
                    end
                    default: ;
                endcase
            end
            S_FILL: begin
                wn_en   = 1'b1;
                wn_addr = r_idx;
                wn_data = fill_last ? ille_pkg::NONE : ({1'b0, r_idx} + LW'(1));
                wp_en   = 1'b1;
                wp_addr = r_idx;
                wp_data = (r_idx == '0) ? ille_pkg::NONE : ({1'b0, r_idx} - LW'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
            r_niu       <= LW'(ille_pkg::NODE_SLOTS);
            for (int i = 0; i < ille_pkg::LIST_COUNT; i++) begin
                r_head[i]  <= ille_pkg::NONE;
                r_tail[i]  <= ille_pkg::NONE;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_niu <= (i_cfg_data > LW'(ille_pkg::NODE_SLOTS)) ?
                         LW'(ille_pkg::NODE_SLOTS) : i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_operation;
                        r_sel   <= i_list_select;
                        r_node  <= $unsigned(i_node_index);
                        r_anc   <= $unsigned(i_anchor_index);
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_status <= 1'b1;
                    r_res    <= ille_pkg::NONE;
                    r_state  <= S_FIN;
                    case (r_op)
                        ille_pkg::OP_CLEAR: begin
                            r_head[r_sel]  <= ille_pkg::NONE;
                            r_tail[r_sel]  <= ille_pkg::NONE;
                            r_count[r_sel] <= '0;
                            r_status       <= 1'b0;
                        end
                        ille_pkg::OP_APPEND: begin
                            if (node_ok && !full) begin
                                if (empty) r_head[r_sel] <= r_node;
                                r_tail[r_sel]  <= r_node;
                                r_count[r_sel] <= cur_cnt + LW'(1);
                                r_status       <= 1'b0;
                                r_state        <= S_LINK2;
                            end
                        end
                        ille_pkg::OP_INS_HEAD: begin
                            if (node_ok && !full) begin
                                if (empty) r_tail[r_sel] <= r_node;
                                r_head[r_sel]  <= r_node;
                                r_count[r_sel] <= cur_cnt + LW'(1);
                                r_status       <= 1'b0;
                                r_state        <= S_LINK2;
                            end
                        end
                        ille_pkg::OP_INS_BEFORE, ille_pkg::OP_INS_AFTER: begin
                            if (node_ok && anc_ok && !empty && !full) r_state <= S_LINK;
                        end
                        ille_pkg::OP_DELETE: begin
                            if (node_ok && !empty) r_state <= S_LINK;
                        end
                        ille_pkg::OP_POP_HEAD, ille_pkg::OP_POP_TAIL: begin
                            if (!empty && !pos[LW-1]) begin
                                r_node  <= pos;
                                r_state <= S_LINK;
                            end
                        end
                        ille_pkg::OP_NEXT, ille_pkg::OP_PREV: begin
                            if (node_ok) r_state <= S_LINK;
                        end
                        ille_pkg::OP_CHECK: begin
                            r_at    <= cur_head;
                            r_seen  <= '0;
                            r_dir   <= 1'b0;
                            r_state <= S_WALK;
                        end
                        ille_pkg::OP_FILL: begin
                            if (r_niu == '0) begin
                                r_head[r_sel]  <= ille_pkg::NONE;
                                r_tail[r_sel]  <= ille_pkg::NONE;
                                r_count[r_sel] <= '0;
                                r_status       <= 1'b0;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_FILL;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LINK: begin
                    r_state <= S_FIN;
                    case (r_op)
                        ille_pkg::OP_INS_BEFORE: begin
                            r_tmp   <= prv_q;
                            r_state <= S_LINK2;
                        end
                        ille_pkg::OP_INS_AFTER: begin
                            r_tmp   <= nxt_q;
                            r_state <= S_LINK2;
                        end
                        ille_pkg::OP_DELETE, ille_pkg::OP_POP_HEAD, ille_pkg::OP_POP_TAIL: begin
                            r_count[r_sel] <= cur_cnt - LW'(1);
                            if (prv_q == ille_pkg::NONE) r_head[r_sel] <= nxt_q;
                            if (nxt_q == ille_pkg::NONE) r_tail[r_sel] <= prv_q;
                            r_res    <= (r_op == ille_pkg::OP_DELETE) ? nxt_q : r_node;
                            r_status <= 1'b0;
                        end
                        ille_pkg::OP_NEXT: begin
                            r_res    <= nxt_q;
                            r_status <= 1'b0;
                        end
                        ille_pkg::OP_PREV: begin
                            r_res    <= prv_q;
                            r_status <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_LINK2: begin
                    r_state <= S_FIN;
                    case (r_op)
                        ille_pkg::OP_INS_BEFORE: begin
                            if (r_tmp == ille_pkg::NONE) r_head[r_sel] <= r_node;
                            r_count[r_sel] <= cur_cnt + LW'(1);
                            r_status       <= 1'b0;
                        end
                        ille_pkg::OP_INS_AFTER: begin
                            if (r_tmp == ille_pkg::NONE) r_tail[r_sel] <= r_node;
                            r_count[r_sel] <= cur_cnt + LW'(1);
                            r_status       <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_WALK: begin
                    // status stays 1 unless both directions pass
                    if (r_at == ille_pkg::NONE) begin
                        if (r_seen != cur_cnt) begin
                            r_state <= S_FIN;
                        end else if (r_dir) begin
                            r_status <= 1'b0;
                            r_state  <= S_FIN;
                        end else begin
                            r_dir  <= 1'b1;
                            r_at   <= cur_tail;
                            r_seen <= '0;
                        end
                    end else if (r_at[LW-1] || ({1'b0, r_at[IW-1:0]} >= r_niu)) begin
                        r_state <= S_FIN;
                    end else if ((r_seen + LW'(1)) > cur_cnt) begin
                        r_state <= S_FIN;
                    end else begin
                        r_seen  <= r_seen + LW'(1);
                        r_state <= S_WWAIT;
                    end
                end
                S_WWAIT: begin
                    r_at    <= r_dir ? prv_q : nxt_q;
                    r_state <= S_WALK;
                end
                S_FILL: begin
                    if (fill_last) begin
                        r_head[r_sel]  <= '0;
                        r_tail[r_sel]  <= {1'b0, r_idx};
                        r_count[r_sel] <= r_niu;
                        r_status       <= 1'b0;
                        r_state        <= S_FIN;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_res    <= r_res;
                        r_out_head   <= cur_head;
                        r_out_tail   <= cur_tail;
                        r_out_count  <= cur_cnt;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_index = $signed(r_out_res);
    assign o_list_head    = $signed(r_out_head);
    assign o_list_tail    = $signed(r_out_tail);
    assign o_list_count   = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_cnt <= LW'(ille_pkg::NODE_SLOTS))
        else $error("list count above node slots");

    a_niu_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_niu <= LW'(ille_pkg::NODE_SLOTS))
        else $error("nodes_in_use not saturated");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish step");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

endmodule
